/* design/bfre_pkg.sv */
// Shared types and constants for the bitmap free-run extractor.
package bfre_pkg;

  localparam int BYTE_BITS = 8;   // blocks covered by one bitmap byte
  localparam int MAX_REC   = 6;   // most records one byte can cause
  localparam int REC_IDX_W = 3;   // index / count over MAX_REC records
  localparam int BLK_W     = 33;  // block numbers and block counts
  localparam int TOT_W     = 32;  // total_blocks and run start block
  localparam int BSZ_W     = 31;  // block_size
  localparam int BYTES_W   = 62;  // byte quantities

  // Record kinds as they appear on the result channel.
  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Register indexes, taken from paddr[2].
  localparam logic REG_TOTAL_BLOCKS = 1'b0;
  localparam logic REG_BLOCK_SIZE   = 1'b1;

  // One record found inside a byte, in bit positions relative to the byte.
  typedef struct packed {
    logic       is_sum;     // summary record
    logic       from_open;  // run started before this byte
    logic [2:0] sidx;       // bit where the run started in this byte
    logic [3:0] eidx;       // bit just past the run (0 to 8)
  } slot_t;

  // Everything a byte produced, with the context needed to rebuild block numbers.
  typedef struct packed {
    logic [BLK_W-1:0]         base;   // block number of bit 7 of the byte
    logic [TOT_W-1:0]         ors;    // start of a run opened in an earlier byte
    logic [BLK_W-1:0]         fcnt;   // free block count after the byte
    logic [REC_IDX_W-1:0]     cnt;    // number of valid slots
    slot_t [MAX_REC-1:0]      slots;
  } rec_group_t;

endpackage

/* design/bfre_scan.sv */
// Scan state and per-byte free run detection for the bitmap free-run extractor.
module bfre_scan
  import bfre_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 scan_en,
  input  logic [BYTE_BITS-1:0] bitmap_byte,
  input  logic [TOT_W-1:0]     total_blocks,
  output rec_group_t           grp
);

  logic [BLK_W-1:0] next_block_r, next_block_nxt;
  logic             run_open_r, run_open_nxt;
  logic [TOT_W-1:0] open_start_r, open_start_nxt;
  logic [BLK_W-1:0] free_cnt_r, free_cnt_nxt;

  logic [BLK_W-1:0]     rem;
  logic                 done;
  logic                 hit_end;
  logic [3:0]           nvalid;
  logic                 run_live;
  logic                 from_open;
  logic [2:0]           sidx;
  logic [REC_IDX_W-1:0] cnt;
  logic [3:0]           nfree;
  slot_t [MAX_REC-1:0]  slots;

  // The bits that still lie below total_blocks are found with one subtract;
  // the walk over the eight bits then only carries narrow run state.
  always_comb begin
    rem     = {1'b0, total_blocks} - next_block_r;
    done    = next_block_r >= {1'b0, total_blocks};
    hit_end = !done && (rem <= BLK_W'(BYTE_BITS));
    nvalid  = done ? 4'd0 : (hit_end ? rem[3:0] : 4'(BYTE_BITS));

    run_live  = run_open_r;
    from_open = run_open_r;
    sidx      = '0;
    cnt       = '0;
    nfree     = '0;
    slots     = '0;

    for (int i = 0; i < BYTE_BITS; i++) begin
      if (4'(i) < nvalid) begin
        if (!bitmap_byte[BYTE_BITS-1-i]) begin
          nfree = nfree + 4'd1;
          if (!run_live) begin
            run_live  = 1'b1;
            from_open = 1'b0;
            sidx      = 3'(i);
          end
        end else if (run_live) begin
          slots[cnt] = '{is_sum: 1'b0, from_open: from_open, sidx: sidx, eidx: 4'(i)};
          cnt        = cnt + 3'd1;
          run_live   = 1'b0;
        end
        if (hit_end && (4'(i + 1) == nvalid)) begin
          if (run_live) begin
            slots[cnt] = '{is_sum: 1'b0, from_open: from_open, sidx: sidx,
                           eidx: 4'(i + 1)};
            cnt        = cnt + 3'd1;
            run_live   = 1'b0;
          end
          slots[cnt] = '{is_sum: 1'b1, from_open: 1'b0, sidx: 3'd0, eidx: 4'd0};
          cnt        = cnt + 3'd1;
        end
      end
    end

    free_cnt_nxt   = free_cnt_r + BLK_W'(nfree);
    next_block_nxt = next_block_r + BLK_W'(nvalid);
    run_open_nxt   = run_live;
    open_start_nxt = (run_live && !from_open) ?
                     (next_block_r[TOT_W-1:0] + TOT_W'(sidx)) : open_start_r;

    grp.base  = next_block_r;
    grp.ors   = open_start_r;
    grp.fcnt  = free_cnt_nxt;
    grp.cnt   = cnt;
    grp.slots = slots;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_block_r <= '0;
      run_open_r   <= 1'b0;
      open_start_r <= '0;
      free_cnt_r   <= '0;
    end else if (scan_en) begin
      next_block_r <= next_block_nxt;
      run_open_r   <= run_open_nxt;
      open_start_r <= open_start_nxt;
      free_cnt_r   <= free_cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    grp.cnt <= REC_IDX_W'(MAX_REC))
    else $error("more records than one byte can produce");

  a_block_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    scan_en |=> next_block_r >= $past(next_block_r))
    else $error("block position moved backward");

  a_summary_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (grp.cnt != '0) && grp.slots[grp.cnt - 3'd1].is_sum |-> !run_open_nxt)
    else $error("run left open after summary");

endmodule

/* design/bitmap_free_run_extractor.sv */
// Top level of the bitmap free-run extractor: register port, record queue and byte math.
//
//  Channel   Direction  Handshake                        Payload
//  input     in         in_valid / in_ready              in_bitmap_byte
//  result    out        out_valid / out_ready            out_kind ... out_last
//  config    in         psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// One bitmap byte is taken per cycle as long as each byte yields at most one
// record and the result channel does not stall. A byte that yields several
// records (up to six) holds the input until its last record moves on, because
// the record drain stage hands out one record per cycle.
// Reset is synchronous and active low; it restores total_blocks to 1,
// block_size to 4096 and clears the scan position and the image offset.
// When out_ready is low the stages fill behind the output register and
// in_ready drops only once the record stage is busy and cannot move.
module bitmap_free_run_extractor
  import bfre_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Bitmap input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_BITS-1:0] in_bitmap_byte,
  // Records
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [TOT_W-1:0]     out_run_start_block,
  output logic [BLK_W-1:0]     out_run_end_block,
  output logic [BYTES_W-1:0]   out_device_offset_bytes,
  output logic [BYTES_W-1:0]   out_run_length_bytes,
  output logic [BYTES_W-1:0]   out_image_offset_bytes,
  output logic [BYTES_W-1:0]   out_total_free_bytes,
  output logic                 out_last
);

  // ---------------------------------------------------------------------------
  // Registers. Writes complete in the access phase; there are no wait states.
  // ---------------------------------------------------------------------------
  logic [TOT_W-1:0] total_blocks_r;
  logic [BSZ_W-1:0] block_size_r;
  logic             reg_idx;
  logic             reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= TOT_W'(1);
      block_size_r   <= BSZ_W'(4096);
    end else if (reg_wr) begin
      case (reg_idx)
        REG_TOTAL_BLOCKS: total_blocks_r <= pwdata[TOT_W-1:0];
        REG_BLOCK_SIZE:   block_size_r   <= pwdata[BSZ_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TOTAL_BLOCKS: prdata = total_blocks_r;
      REG_BLOCK_SIZE:   prdata = {1'b0, block_size_r};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. Each stage moves when the one after it is empty or moving.
  // ---------------------------------------------------------------------------
  logic       in_fire;
  logic       s1_load, s1_last, s1_done;
  logic       s2_load, s2_move, s2_free;
  logic       s3_move, s3_free;
  logic       s4_free;
  logic       out_valid_r;
  logic       s1_vld_r, s2_vld_r, s3_vld_r;
  rec_group_t scan_grp;

  assign s4_free  = !out_valid_r || out_ready;
  assign s3_move  = s3_vld_r && s4_free;
  assign s3_free  = !s3_vld_r || s3_move;
  assign s2_move  = s2_vld_r && s3_free;
  assign s2_free  = !s2_vld_r || s2_move;
  assign s2_load  = s1_vld_r && s2_free;
  assign s1_done  = s2_load && s1_last;
  assign in_ready = !s1_vld_r || s1_done;
  assign in_fire  = in_valid && in_ready;
  // A byte that closes no run and ends no scan only advances the scan state.
  assign s1_load  = in_fire && (scan_grp.cnt != '0);

  // ---------------------------------------------------------------------------
  // Scan: run detection for one byte, state advances on every byte transfer.
  // ---------------------------------------------------------------------------
  bfre_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .scan_en      (in_fire),
    .bitmap_byte  (in_bitmap_byte),
    .total_blocks (total_blocks_r),
    .grp          (scan_grp)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: the byte's record list, drained one record per cycle while stage 2 can take it.
  // ---------------------------------------------------------------------------
  rec_group_t           s1_grp_r;
  logic [REC_IDX_W-1:0] s1_ptr_r;
  slot_t                cur;

  assign cur     = s1_grp_r.slots[s1_ptr_r];
  assign s1_last = (s1_ptr_r == (s1_grp_r.cnt - 3'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_ptr_r <= '0;
    end else if (s1_load) begin
      s1_vld_r <= 1'b1;
      s1_ptr_r <= '0;
    end else if (s1_done) begin
      s1_vld_r <= 1'b0;
    end else if (s2_load) begin
      s1_ptr_r <= s1_ptr_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_grp_r <= scan_grp;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: block numbers of the record and the block count to be scaled.
  // ---------------------------------------------------------------------------
  logic             s2_kind_r, s2_last_r;
  logic [TOT_W-1:0] s2_start_r;
  logic [BLK_W-1:0] s2_end_r, s2_mop_r;
  logic [TOT_W-1:0] s2_start_nxt;
  logic [BLK_W-1:0] s2_end_nxt;

  assign s2_start_nxt = cur.from_open ? s1_grp_r.ors :
                        (s1_grp_r.base[TOT_W-1:0] + TOT_W'(cur.sidx));
  assign s2_end_nxt   = s1_grp_r.base + BLK_W'(cur.eidx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_free) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_kind_r  <= cur.is_sum ? KIND_SUMMARY : KIND_RUN;
      s2_start_r <= s2_start_nxt;
      s2_end_r   <= s2_end_nxt;
      // A summary scales the free block count, a run its own length.
      s2_mop_r   <= cur.is_sum ? s1_grp_r.fcnt : (s2_end_nxt - {1'b0, s2_start_nxt});
      s2_last_r  <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: byte quantities, two multipliers side by side.
  // ---------------------------------------------------------------------------
  logic                     s3_kind_r, s3_last_r;
  logic [TOT_W-1:0]         s3_start_r;
  logic [BLK_W-1:0]         s3_end_r;
  logic [BYTES_W-1:0]       s3_dev_r, s3_prod_r;
  logic [TOT_W+BSZ_W-1:0]   dev_full;
  logic [BLK_W+BSZ_W-1:0]   prod_full;

  assign dev_full  = s2_start_r * block_size_r;
  assign prod_full = s2_mop_r * block_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_free) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_kind_r  <= s2_kind_r;
      s3_last_r  <= s2_last_r;
      s3_start_r <= s2_start_r;
      s3_end_r   <= s2_end_r;
      s3_dev_r   <= dev_full[BYTES_W-1:0];
      s3_prod_r  <= prod_full[BYTES_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: output register. Each run takes the current packed-image offset
  // and moves it forward by its own length.
  // ---------------------------------------------------------------------------
  logic [BYTES_W-1:0] img_acc_r;
  logic               run_rec;

  assign run_rec = (s3_kind_r == KIND_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      img_acc_r   <= '0;
    end else begin
      if (s3_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s3_move && run_rec) begin
        img_acc_r <= img_acc_r + s3_prod_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_move) begin
      out_kind                <= s3_kind_r;
      out_last                <= s3_last_r;
      out_run_start_block     <= run_rec ? s3_start_r : '0;
      out_run_end_block       <= run_rec ? s3_end_r : '0;
      out_device_offset_bytes <= run_rec ? s3_dev_r : '0;
      out_run_length_bytes    <= run_rec ? s3_prod_r : '0;
      out_image_offset_bytes  <= run_rec ? img_acc_r : '0;
      out_total_free_bytes    <= run_rec ? '0 : s3_prod_r;
    end
  end

  assign out_valid = out_valid_r;

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> s1_ptr_r < s1_grp_r.cnt)
    else $error("record pointer past the end of the list");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind == KIND_SUMMARY) |-> out_last)
    else $error("summary record not marked last");

  a_list_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> s1_vld_r && (s1_ptr_r == '0))
    else $error("record list not started from its first entry");

endmodule

/* tb/sv/bfre_record_check.sv */
// Record checker for the bitmap free-run extractor: register tracking, scan prediction, compare.
module bfre_record_check
  import bfre_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BYTE_BITS-1:0] in_bitmap_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_kind,
  input  logic [TOT_W-1:0]     out_run_start_block,
  input  logic [BLK_W-1:0]     out_run_end_block,
  input  logic [BYTES_W-1:0]   out_device_offset_bytes,
  input  logic [BYTES_W-1:0]   out_run_length_bytes,
  input  logic [BYTES_W-1:0]   out_image_offset_bytes,
  input  logic [BYTES_W-1:0]   out_total_free_bytes,
  input  logic                 out_last,
  output int unsigned          fail_count,
  output int unsigned          pending_records
);

  typedef struct packed {
    logic               kind;
    logic [TOT_W-1:0]   start_blk;
    logic [BLK_W-1:0]   end_blk;
    logic [BYTES_W-1:0] dev_off;
    logic [BYTES_W-1:0] len_bytes;
    logic [BYTES_W-1:0] img_off;
    logic [BYTES_W-1:0] free_bytes;
    logic               last;
  } free_run_rec_t;

  // Register copies.
  logic [TOT_W-1:0]   total_blk;
  logic [BSZ_W-1:0]   blk_bytes;

  // Scan state.
  logic [BLK_W-1:0]   blk_pos;
  logic               run_is_open;
  logic [TOT_W-1:0]   run_first;
  logic [BLK_W-1:0]   free_blocks;
  logic [BYTES_W-1:0] image_pos;

  free_run_rec_t awaited_records[$];

  initial begin
    fail_count = 0;
    pending_records = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < 100)
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Closes the open run at block stop and advances the packed-image offset.
  function automatic free_run_rec_t close_run(input logic [BLK_W-1:0] stop);
    free_run_rec_t r;
    logic [63:0]   len;
    len = 64'(stop - {1'b0, run_first}) * 64'(blk_bytes);
    r = '0;
    r.kind = KIND_RUN;
    r.start_blk = run_first;
    r.end_blk = stop;
    r.dev_off = BYTES_W'(64'(run_first) * 64'(blk_bytes));
    r.len_bytes = len[BYTES_W-1:0];
    r.img_off = image_pos;
    image_pos = image_pos + len[BYTES_W-1:0];
    return r;
  endfunction

  function automatic free_run_rec_t summary_rec();
    free_run_rec_t r;
    r = '0;
    r.kind = KIND_SUMMARY;
    r.free_bytes = BYTES_W'(64'(free_blocks) * 64'(blk_bytes));
    return r;
  endfunction

  task automatic scan_bitmap_byte(input logic [BYTE_BITS-1:0] bits);
    free_run_rec_t batch[$];
    for (int i = 0; i < BYTE_BITS; i++) begin
      if (blk_pos >= {1'b0, total_blk}) break;
      if (!bits[BYTE_BITS-1-i]) begin
        if (!run_is_open) begin
          run_first = blk_pos[TOT_W-1:0];
          run_is_open = 1'b1;
        end
        free_blocks = free_blocks + 1'b1;
      end else if (run_is_open) begin
        batch.push_back(close_run(blk_pos));
        run_is_open = 1'b0;
      end
      blk_pos = blk_pos + 1'b1;
      if (blk_pos == {1'b0, total_blk}) begin
        if (run_is_open) begin
          batch.push_back(close_run(blk_pos));
          run_is_open = 1'b0;
        end
        batch.push_back(summary_rec());
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) awaited_records.push_back(batch[k]);
  endtask

  task automatic check_record();
    free_run_rec_t want;
    if (awaited_records.size() == 0) begin
      report_mismatch("record with none awaited, kind", 64'(out_kind), 64'd0);
    end else begin
      want = awaited_records.pop_front();
      if (out_kind != want.kind)
        report_mismatch("kind", 64'(out_kind), 64'(want.kind));
      if (out_run_start_block != want.start_blk)
        report_mismatch("run_start_block", 64'(out_run_start_block), 64'(want.start_blk));
      if (out_run_end_block != want.end_blk)
        report_mismatch("run_end_block", 64'(out_run_end_block), 64'(want.end_blk));
      if (out_device_offset_bytes != want.dev_off)
        report_mismatch("device_offset_bytes", 64'(out_device_offset_bytes),
                        64'(want.dev_off));
      if (out_run_length_bytes != want.len_bytes)
        report_mismatch("run_length_bytes", 64'(out_run_length_bytes), 64'(want.len_bytes));
      if (out_image_offset_bytes != want.img_off)
        report_mismatch("image_offset_bytes", 64'(out_image_offset_bytes),
                        64'(want.img_off));
      if (out_total_free_bytes != want.free_bytes)
        report_mismatch("total_free_bytes", 64'(out_total_free_bytes),
                        64'(want.free_bytes));
      if (out_last != want.last)
        report_mismatch("last", 64'(out_last), 64'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      total_blk = 32'd1;
      blk_bytes = 31'd4096;
      blk_pos = '0;
      run_is_open = 1'b0;
      run_first = '0;
      free_blocks = '0;
      image_pos = '0;
      awaited_records.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_TOTAL_BLOCKS: total_blk = pwdata;
          REG_BLOCK_SIZE:   blk_bytes = pwdata[BSZ_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) scan_bitmap_byte(in_bitmap_byte);
      if (out_valid && out_ready) check_record();
    end
    pending_records = awaited_records.size();
  end

endmodule

/* tb/sv/bitmap_free_run_extractor_tb.sv */
// Top of the bitmap free-run extractor testbench: clock, reset, stimulus and verdict.
module bitmap_free_run_extractor_tb;
  import bfre_pkg::*;

  // Long enough for every transfer to meet its worst stall several times over.
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Receiver hold-off long enough for the block to fill and drop in_ready.
  localparam int LONG_STALL  = 400;
  // Drain time after the last expected record.
  localparam int SETTLE      = 8;
  // Least number of bitmap bytes offered over the whole run, directed phases included.
  localparam int TOTAL_ITEMS = 130;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_BITS-1:0] in_bitmap_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_kind;
  logic [TOT_W-1:0]     out_run_start_block;
  logic [BLK_W-1:0]     out_run_end_block;
  logic [BYTES_W-1:0]   out_device_offset_bytes;
  logic [BYTES_W-1:0]   out_run_length_bytes;
  logic [BYTES_W-1:0]   out_image_offset_bytes;
  logic [BYTES_W-1:0]   out_total_free_bytes;
  logic                 out_last;

  int unsigned fail_count;
  int unsigned pending_records;
  int unsigned cycle_count = 0;

  // Stimulus shaping shared by the sender and the receiver.
  logic steady = 1'b0;          // no idle cycles on either side while set
  logic long_stall_req = 1'b0;  // asks the receiver for one long hold-off

  // The sender's view of where the scan stands, used to place total_blocks.
  logic [BLK_W-1:0] scan_pos;
  logic [TOT_W-1:0] total_now;
  int               sent;
  int               span;
  int               n_bytes;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bitmap_free_run_extractor dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_bitmap_byte          (in_bitmap_byte),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_kind                (out_kind),
    .out_run_start_block     (out_run_start_block),
    .out_run_end_block       (out_run_end_block),
    .out_device_offset_bytes (out_device_offset_bytes),
    .out_run_length_bytes    (out_run_length_bytes),
    .out_image_offset_bytes  (out_image_offset_bytes),
    .out_total_free_bytes    (out_total_free_bytes),
    .out_last                (out_last)
  );

  bfre_record_check record_check (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .pready                  (pready),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_bitmap_byte          (in_bitmap_byte),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_kind                (out_kind),
    .out_run_start_block     (out_run_start_block),
    .out_run_end_block       (out_run_end_block),
    .out_device_offset_bytes (out_device_offset_bytes),
    .out_run_length_bytes    (out_run_length_bytes),
    .out_image_offset_bytes  (out_image_offset_bytes),
    .out_total_free_bytes    (out_total_free_bytes),
    .out_last                (out_last),
    .fail_count              (fail_count),
    .pending_records         (pending_records)
  );

  // Watchdog: a hung handshake or a lost record ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then a long gap.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bitmap content: uniform bytes, solid free or allocated bytes, alternating
  // patterns that close many runs in one byte, and sparse or dense bytes that
  // make long runs.
  function automatic logic [7:0] pick_bitmap_byte();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return 8'($urandom);
      4:          return 8'h00;
      5:          return 8'hFF;
      6:          return ($urandom_range(0, 1) != 0) ? 8'hAA : 8'h55;
      7, 8:       return 8'($urandom & $urandom & $urandom);
      default:    return 8'($urandom | $urandom | $urandom);
    endcase
  endfunction

  // Block sizes: both ends of the stated range, the reset value, values
  // beyond the range on either side, and random ones in between.
  function automatic logic [31:0] pick_block_size();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'd512;
      1:       return 32'd1073741824;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'd4096;
      4:       return 32'($urandom_range(0, 511));
      default: return 32'($urandom_range(512, 1073741824));
    endcase
  endfunction

  // Register write: setup cycle, then access cycle until pready. psel, penable
  // and pwrite then drop so that back-to-back writes never touch psel twice in a step.
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (reg_idx == REG_TOTAL_BLOCKS) total_now = value;
  endtask

  // Offers one bitmap byte and returns at the edge of its transfer. Valid
  // stays high into the next call when no gap is picked.
  task automatic send_byte(input logic [7:0] bits);
    int gap;
    gap = pick_idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_bitmap_byte <= bits;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (scan_pos < {1'b0, total_now}) begin
      scan_pos = (scan_pos + 8 > {1'b0, total_now}) ? {1'b0, total_now} : scan_pos + 8;
    end
  endtask

  // Drops valid, waits for every expected record, then lets the pipeline
  // settle, since the last byte may have caused nothing at all.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_records != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: random ready with bursts, and one long hold-off on request.
  initial begin
    int idle;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_stall_req) begin
        long_stall_req <= 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        idle = pick_idle_len();
        if (idle > 0) begin
          out_ready <= 1'b0;
          repeat (idle) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Sender and verdict.
  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_bitmap_byte = '0;
    scan_pos       = '0;
    total_now      = 32'd1;
    sent           = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings cover a single block: one free block gives a run and
    // the summary, and every byte after the summary is ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    drain();

    // Smallest block size over 32 blocks. A run crosses a byte boundary, one
    // byte closes four runs, and the last byte closes four runs, ends the
    // scan with a trailing run and adds the summary: six records from one byte.
    write_reg(REG_BLOCK_SIZE, 32'd512);
    write_reg(REG_TOTAL_BLOCKS, 32'(scan_pos + 32));
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hFE);
    send_byte(8'hAA);
    drain();

    // Largest block size; the scan ends in the middle of a byte, so the low
    // bits of that byte and the whole byte after it are past the end.
    write_reg(REG_BLOCK_SIZE, 32'd1073741824);
    write_reg(REG_TOTAL_BLOCKS, 32'(scan_pos + 20));
    send_byte(8'hFF);
    send_byte(8'h0F);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();

    // All-ones block size, beyond the stated range, with one long run.
    write_reg(REG_BLOCK_SIZE, 32'h7FFF_FFFF);
    write_reg(REG_TOTAL_BLOCKS, 32'(scan_pos + 24));
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();

    // Zero total blocks: nothing is scanned and no summary appears.
    write_reg(REG_TOTAL_BLOCKS, 32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    // Settings changed in the middle of a scan. A run opens under one block
    // size, the size changes and the next byte closes it and opens another,
    // then the total drops below the scan position so a byte is ignored, and
    // finally the total is raised again and that second run closes at the end.
    write_reg(REG_BLOCK_SIZE, 32'd4096);
    write_reg(REG_TOTAL_BLOCKS, 32'(scan_pos + 24));
    send_byte(8'hF0);
    drain();
    write_reg(REG_BLOCK_SIZE, 32'd1024);
    send_byte(8'h0E);
    drain();
    write_reg(REG_TOTAL_BLOCKS, 32'd1);
    send_byte(8'h00);
    drain();
    write_reg(REG_TOTAL_BLOCKS, 32'(scan_pos + 8));
    send_byte(8'h00);
    drain();

    // Largest total and a long receiver hold-off while the sender keeps
    // offering bytes back to back, so the record queue fills and the input
    // stalls. The scan stays open; a later phase sets a reachable end.
    steady <= 1'b1;
    write_reg(REG_BLOCK_SIZE, pick_block_size());
    write_reg(REG_TOTAL_BLOCKS, 32'hFFFF_FFFF);
    long_stall_req <= 1'b1;
    repeat (30) send_byte(pick_bitmap_byte());
    drain();

    // Random phases: each picks a block size and a scan end a random number
    // of blocks ahead, sends just enough bytes plus a little noise past the
    // end, and waits for the block to go idle before the next settings.
    while (sent < TOTAL_ITEMS) begin
      steady <= ($urandom_range(0, 3) == 0);
      write_reg(REG_BLOCK_SIZE, pick_block_size());
      span = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      write_reg(REG_TOTAL_BLOCKS, 32'(scan_pos + span));
      n_bytes = (span + 7) / 8 + $urandom_range(0, 2);
      repeat (n_bytes) send_byte(pick_bitmap_byte());
      drain();
    end

    @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
